>>> rtl/oupe_pkg.sv
package oupe_pkg;

  localparam int MAX_SAMPLES = 4096;
  localparam int MIN_SAMPLES = 3;
  localparam int CNT_W = 17;
  localparam int MUL_W = 64;
  localparam int DIV_W = 128;
  localparam int LOG_W = 30;
  localparam int LOG_FRAC = 24;
  localparam logic [31:0] LN2_Q32 = 32'd2977044472;

  typedef enum logic [2:0] {
    STAT_OK       = 3'd0,
    STAT_TOO_FEW  = 3'd1,
    STAT_TOO_MANY = 3'd2,
    STAT_ZERO_DEN = 3'd3,
    STAT_BAD_LOG  = 3'd4
  } status_t;

  // estimation steps, executed in this order
  typedef enum logic [4:0] {
    OP_CHK, OP_P1, OP_P2, OP_P3, OP_P4, OP_DENZ, OP_MEAN,
    OP_MX, OP_MY, OP_MM, OP_NMM, OP_ABC, OP_ABCHK,
    OP_LA, OP_LB, OP_LN, OP_NN, OP_DD, OP_SHIFT, OP_DZ, OP_G,
    OP_CA, OP_BB, OP_AN, OP_S2, OP_F, OP_V
  } op_t;

  typedef enum logic [1:0] {
    CS_IDLE, CS_ISSUE, CS_WAIT, CS_DONE
  } ctrl_state_t;

  typedef enum logic [1:0] {
    LG_IDLE, LG_NORM, LG_SQ, LG_FIX
  } log_phase_t;

  typedef struct packed {
    logic accum;
    logic issue;
    logic finish;
    logic load;
    op_t  op;
  } dp_cmd_t;

  typedef struct packed {
    logic done;
    logic stop;
    logic out_free;
  } dp_sts_t;

  function automatic logic [63:0] mag64(input logic signed [63:0] v);
    return v[63] ? 64'(-v) : 64'(v);
  endfunction

endpackage

>>> rtl/oupe_mul.sv
module oupe_mul (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [oupe_pkg::MUL_W-1:0]    a,
  input  logic [oupe_pkg::MUL_W-1:0]    b,
  output logic                          done,
  output logic [2*oupe_pkg::MUL_W-1:0]  prod
);

  logic                                   busy;
  logic [$clog2(oupe_pkg::MUL_W)-1:0]     cnt;
  logic [2*oupe_pkg::MUL_W-1:0]           mc;
  logic [oupe_pkg::MUL_W-1:0]             mb;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == $bits(cnt)'(oupe_pkg::MUL_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // shift-add, one multiplier bit per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      prod <= '0;
      mc   <= (2*oupe_pkg::MUL_W)'(a);
      mb   <= b;
    end else if (busy) begin
      if (mb[0]) prod <= prod + mc;
      mc <= {mc[2*oupe_pkg::MUL_W-2:0], 1'b0};
      mb <= {1'b0, mb[oupe_pkg::MUL_W-1:1]};
    end
  end

endmodule

>>> rtl/oupe_div.sv
module oupe_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [oupe_pkg::DIV_W-1:0] num,
  input  logic [oupe_pkg::DIV_W-1:0] den,
  output logic                      done,
  output logic [oupe_pkg::DIV_W-1:0] quo
);

  logic                                busy;
  logic [$clog2(oupe_pkg::DIV_W)-1:0]  cnt;
  logic [oupe_pkg::DIV_W-1:0]          rem, nsh, dreg, rs;
  logic                                ge;

  assign rs = {rem[oupe_pkg::DIV_W-2:0], nsh[oupe_pkg::DIV_W-1]};
  assign ge = (rs >= dreg);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == $bits(cnt)'(oupe_pkg::DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // restoring division, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      nsh  <= num;
      quo  <= '0;
      dreg <= den;
    end else if (busy) begin
      rem <= ge ? rs - dreg : rs;
      quo <= {quo[oupe_pkg::DIV_W-2:0], ge};
      nsh <= {nsh[oupe_pkg::DIV_W-2:0], 1'b0};
    end
  end

endmodule

>>> rtl/oupe_log2.sv
module oupe_log2 (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [63:0]                v,
  output logic                       done,
  output logic [oupe_pkg::LOG_W-1:0] res
);

  oupe_pkg::log_phase_t phase, phase_next;
  logic [63:0] w;
  logic [5:0]  sh;
  logic [31:0] mant;
  logic [63:0] sq;
  logic [32:0] t;
  logic [4:0]  it;
  logic [oupe_pkg::LOG_FRAC-1:0] frac;
  logic        last_it;

  assign t       = sq[63:31];
  assign last_it = (it == 5'(oupe_pkg::LOG_FRAC - 1));
  assign res     = {6'd63 - sh, frac};

  always_comb begin
    phase_next = phase;
    unique case (phase)
      oupe_pkg::LG_IDLE: if (start) phase_next = oupe_pkg::LG_NORM;
      oupe_pkg::LG_NORM: if (w[63]) phase_next = oupe_pkg::LG_SQ;
      oupe_pkg::LG_SQ:   phase_next = oupe_pkg::LG_FIX;
      oupe_pkg::LG_FIX:  phase_next = last_it ? oupe_pkg::LG_IDLE : oupe_pkg::LG_SQ;
      default:           phase_next = oupe_pkg::LG_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= oupe_pkg::LG_IDLE;
      done  <= 1'b0;
    end else begin
      phase <= phase_next;
      done  <= (phase == oupe_pkg::LG_FIX) && last_it;
    end
  end

  always_ff @(posedge clk) begin
    unique case (phase)
      oupe_pkg::LG_IDLE: begin
        if (start) begin
          w  <= v;
          sh <= '0;
        end
      end
      oupe_pkg::LG_NORM: begin
        // shift until the leading one reaches the top
        if (w[63]) begin
          mant <= w[63:32];
          it   <= '0;
          frac <= '0;
        end else begin
          w  <= {w[62:0], 1'b0};
          sh <= sh + 1'b1;
        end
      end
      oupe_pkg::LG_SQ: sq <= mant * mant;
      oupe_pkg::LG_FIX: begin
        mant <= t[32] ? t[32:1] : t[31:0];
        frac <= {frac[oupe_pkg::LOG_FRAC-2:0], t[32]};
        it   <= it + 1'b1;
      end
      default: ;
    endcase
  end

endmodule

>>> rtl/oupe_datapath.sv
module oupe_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  oupe_pkg::dp_cmd_t    cmd,
  output oupe_pkg::dp_sts_t    sts,
  input  logic signed [15:0]   in_sample,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [71:0]          out_data,
  output logic [2:0]           out_stat
);

  // accumulators
  logic signed [15:0]               prev;
  logic [oupe_pkg::CNT_W-1:0]       cnt, n_cnt;
  logic signed [28:0]               s_x, s_y;
  logic [43:0]                      s_xx, s_yy;
  logic signed [44:0]               s_xy;
  logic signed [31:0]               p_xx, p_yy, p_xy;

  // estimation registers
  logic signed [127:0] num_r, den_r, ps, bb_diff;
  logic                mean_neg;
  logic signed [15:0]  m_r;
  logic signed [63:0]  tmx, tmy, tmm, tnmm, a_r, b_r, c_r;
  logic [oupe_pkg::LOG_W-1:0] la, lb;
  logic [47:0]         l40;
  logic [127:0]        nn_r, dd_r, p_r, f_r;
  logic [63:0]         g_r, s2_r, mag56, amag;
  logic [15:0]         mean_o;
  logic [23:0]         rate_o;
  logic [31:0]         var_o;
  oupe_pkg::status_t   stat_o;
  logic                stop, stop_set, quick_done, shifting, shift_done, mul_sgn;

  // units
  logic         mul_start, div_start, log_start, mul_done, div_done, log_done;
  logic [63:0]  mul_a, mul_b, log_v;
  logic [127:0] mul_p, div_n, div_d, div_q;
  logic [oupe_pkg::LOG_W-1:0] log_res;

  oupe_mul u_mul (.clk, .rst, .start(mul_start), .a(mul_a), .b(mul_b),
                  .done(mul_done), .prod(mul_p));
  oupe_div u_div (.clk, .rst, .start(div_start), .num(div_n), .den(div_d),
                  .done(div_done), .quo(div_q));
  oupe_log2 u_log (.clk, .rst, .start(log_start), .v(log_v),
                   .done(log_done), .res(log_res));

  assign p_xx  = 32'(prev) * 32'(prev);
  assign p_yy  = 32'(in_sample) * 32'(in_sample);
  assign p_xy  = 32'(prev) * 32'(in_sample);
  assign n_cnt = cnt - 1'b1;

  assign ps      = mul_sgn ? -$signed(mul_p) : $signed(mul_p);
  assign bb_diff = $signed(p_r) - ps;
  assign mag56   = mul_p[63:0];
  assign amag    = (mag56 + 64'h0000_0080_0000_0000) >> 40;

  assign sts.done     = mul_done | div_done | log_done | quick_done | shift_done;
  assign sts.stop     = stop;
  assign sts.out_free = !out_valid || out_ready;

  // unit launch and operand select
  always_comb begin
    logic signed [63:0] oa, ob, sx64, sy64, sxx64, sxy64, n64, m64;
    logic uns;
    sx64  = 64'(s_x);
    sy64  = 64'(s_y);
    sxx64 = $signed({20'b0, s_xx});
    sxy64 = 64'(s_xy);
    n64   = $signed({47'b0, n_cnt});
    m64   = 64'(m_r);
    oa = '0; ob = '0; uns = 1'b0;
    mul_a = '0; mul_b = '0;
    mul_start = 1'b0; div_start = 1'b0; log_start = 1'b0;
    div_n = '0; div_d = '0; log_v = '0;
    case (cmd.op) inside
      oupe_pkg::OP_P1:  begin oa = sy64; ob = sxx64; end
      oupe_pkg::OP_P2:  begin oa = sx64; ob = sxy64; end
      oupe_pkg::OP_P3:  begin oa = n64;  ob = sxx64 - sxy64; end
      oupe_pkg::OP_P4:  begin oa = sx64; ob = sx64 - sy64; end
      oupe_pkg::OP_MX:  begin oa = m64;  ob = sx64; end
      oupe_pkg::OP_MY:  begin oa = m64;  ob = sy64; end
      oupe_pkg::OP_MM:  begin oa = m64;  ob = m64; end
      oupe_pkg::OP_NMM: begin oa = n64;  ob = tmm; end
      oupe_pkg::OP_NN:  begin oa = a_r;  ob = a_r; end
      oupe_pkg::OP_DD:  begin oa = a_r - b_r; ob = a_r + b_r; end
      oupe_pkg::OP_CA:  begin oa = c_r[63] ? 64'sd0 : c_r; ob = a_r; end
      oupe_pkg::OP_BB:  begin oa = b_r;  ob = b_r; end
      oupe_pkg::OP_AN:  begin oa = a_r;  ob = n64; end
      oupe_pkg::OP_LN: begin
        uns   = 1'b1;
        mul_a = (la < lb) ? 64'(lb - la) : 64'(la - lb);
        mul_b = 64'(oupe_pkg::LN2_Q32);
      end
      oupe_pkg::OP_F: begin
        uns   = 1'b1;
        mul_a = {15'b0, l40, 1'b0};
        mul_b = g_r;
      end
      oupe_pkg::OP_V: begin
        uns   = 1'b1;
        mul_a = f_r[63:0];
        mul_b = s2_r;
      end
      default: uns = 1'b1;
    endcase
    if (!uns) begin
      mul_a = oupe_pkg::mag64(oa);
      mul_b = oupe_pkg::mag64(ob);
    end
    case (cmd.op) inside
      oupe_pkg::OP_P1, oupe_pkg::OP_P2, oupe_pkg::OP_P3, oupe_pkg::OP_P4,
      oupe_pkg::OP_MX, oupe_pkg::OP_MY, oupe_pkg::OP_MM, oupe_pkg::OP_NMM,
      oupe_pkg::OP_LN, oupe_pkg::OP_NN, oupe_pkg::OP_DD, oupe_pkg::OP_CA,
      oupe_pkg::OP_BB, oupe_pkg::OP_AN, oupe_pkg::OP_F, oupe_pkg::OP_V:
        mul_start = cmd.issue;
      oupe_pkg::OP_MEAN: begin
        div_start = cmd.issue;
        div_n = {num_r[126:0], 1'b0} + den_r;
        div_d = {den_r[126:0], 1'b0};
      end
      oupe_pkg::OP_G: begin
        div_start = cmd.issue;
        div_n = {nn_r[95:0], 32'b0};
        div_d = dd_r;
      end
      oupe_pkg::OP_S2: begin
        div_start = cmd.issue;
        div_n = {p_r[111:0], 16'b0};
        div_d = dd_r;
      end
      oupe_pkg::OP_LA: begin log_start = cmd.issue; log_v = a_r; end
      oupe_pkg::OP_LB: begin log_start = cmd.issue; log_v = b_r; end
      default: ;
    endcase
  end

  always_comb begin
    stop_set = 1'b0;
    if (cmd.finish) begin
      case (cmd.op)
        oupe_pkg::OP_CHK:   stop_set = (cnt > oupe_pkg::CNT_W'(oupe_pkg::MAX_SAMPLES)) ||
                                       (cnt < oupe_pkg::CNT_W'(oupe_pkg::MIN_SAMPLES));
        oupe_pkg::OP_DENZ:  stop_set = (den_r == '0);
        oupe_pkg::OP_ABCHK: stop_set = (a_r <= 0) || (b_r <= 0);
        oupe_pkg::OP_DZ:    stop_set = (dd_r == '0);
        default:            stop_set = 1'b0;
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0; prev <= '0;
      s_x <= '0; s_y <= '0; s_xx <= '0; s_yy <= '0; s_xy <= '0;
      stop <= 1'b0; quick_done <= 1'b0; shifting <= 1'b0; shift_done <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      quick_done <= 1'b0;
      shift_done <= 1'b0;
      if (cmd.issue) begin
        case (cmd.op) inside
          oupe_pkg::OP_CHK, oupe_pkg::OP_DENZ, oupe_pkg::OP_ABC,
          oupe_pkg::OP_ABCHK, oupe_pkg::OP_DZ: quick_done <= 1'b1;
          oupe_pkg::OP_SHIFT: shifting <= 1'b1;
          default: ;
        endcase
      end else if (shifting && nn_r[127:94] == '0) begin
        shifting   <= 1'b0;
        shift_done <= 1'b1;
      end
      if (cmd.load) stop <= 1'b0;
      else if (stop_set) stop <= 1'b1;

      if (cmd.load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;

      if (cmd.load) begin
        // clear for the next series
        cnt <= '0; prev <= '0;
        s_x <= '0; s_y <= '0; s_xx <= '0; s_yy <= '0; s_xy <= '0;
      end else if (cmd.accum) begin
        if (cnt == '0) begin
          prev <= in_sample;
          cnt  <= oupe_pkg::CNT_W'(1);
        end else if (cnt < oupe_pkg::CNT_W'(oupe_pkg::MAX_SAMPLES)) begin
          s_x  <= s_x + 29'(prev);
          s_y  <= s_y + 29'(in_sample);
          s_xx <= s_xx + 44'($unsigned(p_xx));
          s_yy <= s_yy + 44'($unsigned(p_yy));
          s_xy <= s_xy + 45'(p_xy);
          prev <= in_sample;
          cnt  <= cnt + 1'b1;
        end else begin
          cnt <= oupe_pkg::CNT_W'(oupe_pkg::MAX_SAMPLES + 1);
        end
      end
    end
  end

  // estimation payload
  always_ff @(posedge clk) begin
    if (shifting && !cmd.issue && nn_r[127:94] != '0) begin
      nn_r <= nn_r >> 1;
      dd_r <= dd_r >> 1;
    end
    if (mul_start) mul_sgn <= !uns_op(cmd.op) && (sgn_a(cmd.op) ^ sgn_b(cmd.op));
    if (cmd.load) begin
      out_data <= {var_o, rate_o, mean_o};
      out_stat <= stat_o;
    end
    if (cmd.finish) begin
      case (cmd.op)
        oupe_pkg::OP_CHK: begin
          mean_o <= '0; rate_o <= '0; var_o <= '0;
          if (cnt > oupe_pkg::CNT_W'(oupe_pkg::MAX_SAMPLES)) stat_o <= oupe_pkg::STAT_TOO_MANY;
          else if (cnt < oupe_pkg::CNT_W'(oupe_pkg::MIN_SAMPLES)) stat_o <= oupe_pkg::STAT_TOO_FEW;
          else stat_o <= oupe_pkg::STAT_OK;
        end
        oupe_pkg::OP_P1: num_r <= ps;
        oupe_pkg::OP_P2: num_r <= num_r - ps;
        oupe_pkg::OP_P3: den_r <= ps;
        oupe_pkg::OP_P4: den_r <= den_r - ps;
        oupe_pkg::OP_DENZ: begin
          if (den_r == '0) stat_o <= oupe_pkg::STAT_ZERO_DEN;
          // hold magnitudes for the rounded division
          mean_neg <= num_r[127] ^ den_r[127];
          num_r    <= num_r[127] ? -num_r : num_r;
          den_r    <= den_r[127] ? -den_r : den_r;
        end
        oupe_pkg::OP_MEAN: begin
          if (mean_neg) begin
            if (div_q[127:16] != '0 || div_q[15:0] > 16'd32768) begin
              m_r <= -16'sd32768; mean_o <= 16'h8000;
            end else begin
              m_r <= -$signed(div_q[15:0]); mean_o <= 16'(-div_q[15:0]);
            end
          end else begin
            if (div_q[127:15] != '0) begin
              m_r <= 16'sd32767; mean_o <= 16'h7FFF;
            end else begin
              m_r <= $signed({1'b0, div_q[14:0]}); mean_o <= {1'b0, div_q[14:0]};
            end
          end
        end
        oupe_pkg::OP_MX:  tmx  <= ps[63:0];
        oupe_pkg::OP_MY:  tmy  <= ps[63:0];
        oupe_pkg::OP_MM:  tmm  <= ps[63:0];
        oupe_pkg::OP_NMM: tnmm <= ps[63:0];
        oupe_pkg::OP_ABC: begin
          a_r <= $signed({20'b0, s_xx}) - (tmx <<< 1) + tnmm;
          b_r <= 64'(s_xy) - tmx - tmy + tnmm;
          c_r <= $signed({20'b0, s_yy}) - (tmy <<< 1) + tnmm;
        end
        oupe_pkg::OP_ABCHK: if (a_r <= 0 || b_r <= 0) stat_o <= oupe_pkg::STAT_BAD_LOG;
        oupe_pkg::OP_LA: la <= log_res;
        oupe_pkg::OP_LB: lb <= log_res;
        oupe_pkg::OP_LN: begin
          l40 <= mag56[63:16];
          if (la < lb) rate_o <= (amag > 64'd8388608) ? 24'h800000 : 24'(-amag);
          else rate_o <= (amag > 64'd8388607) ? 24'h7FFFFF : amag[23:0];
        end
        oupe_pkg::OP_NN: nn_r <= mul_p;
        oupe_pkg::OP_DD: dd_r <= mul_p;
        oupe_pkg::OP_DZ: if (dd_r == '0) stat_o <= oupe_pkg::STAT_ZERO_DEN;
        oupe_pkg::OP_G:  g_r <= (div_q[127:64] != '0) ? '1 : div_q[63:0];
        oupe_pkg::OP_CA: p_r <= mul_p;
        oupe_pkg::OP_BB: p_r <= bb_diff[127] ? '0 : $unsigned(bb_diff);
        oupe_pkg::OP_AN: dd_r <= mul_p;
        oupe_pkg::OP_S2: s2_r <= (div_q[127:64] != '0) ? '1 : div_q[63:0];
        oupe_pkg::OP_F:  f_r <= mul_p >> 24;
        oupe_pkg::OP_V: begin
          if (f_r[127:64] != '0) var_o <= (s2_r != '0) ? '1 : '0;
          else var_o <= (mul_p[127:96] != '0) ? '1 : mul_p[95:64];
        end
        default: ;
      endcase
    end
  end

  // operand signs for the signed products
  function automatic logic uns_op(input oupe_pkg::op_t op);
    case (op) inside
      oupe_pkg::OP_LN, oupe_pkg::OP_F, oupe_pkg::OP_V: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic sgn_a(input oupe_pkg::op_t op);
    case (op)
      oupe_pkg::OP_P1:  return s_y[28];
      oupe_pkg::OP_P2, oupe_pkg::OP_P4: return s_x[28];
      oupe_pkg::OP_MX, oupe_pkg::OP_MY, oupe_pkg::OP_MM: return m_r[15];
      oupe_pkg::OP_NN, oupe_pkg::OP_AN: return a_r[63];
      oupe_pkg::OP_DD:  return (a_r < b_r);
      oupe_pkg::OP_BB:  return b_r[63];
      default:          return 1'b0;
    endcase
  endfunction

  function automatic logic sgn_b(input oupe_pkg::op_t op);
    logic signed [63:0] d;
    d = 64'sd0;
    case (op)
      oupe_pkg::OP_P2:  return s_xy[44];
      oupe_pkg::OP_P3: begin
        d = $signed({20'b0, s_xx}) - 64'(s_xy);
        return d[63];
      end
      oupe_pkg::OP_P4: begin
        d = 64'(s_x) - 64'(s_y);
        return d[63];
      end
      oupe_pkg::OP_MX:  return s_x[28];
      oupe_pkg::OP_MY:  return s_y[28];
      oupe_pkg::OP_MM:  return m_r[15];
      oupe_pkg::OP_NMM: return tmm[63];
      oupe_pkg::OP_NN:  return a_r[63];
      oupe_pkg::OP_DD: begin
        d = a_r + b_r;
        return d[63];
      end
      oupe_pkg::OP_BB:  return b_r[63];
      default:          return 1'b0;
    endcase
  endfunction

endmodule

>>> rtl/oupe_ctrl.sv
module oupe_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_last,
  output logic              in_ready,
  output oupe_pkg::dp_cmd_t cmd,
  input  oupe_pkg::dp_sts_t sts
);

  oupe_pkg::ctrl_state_t state, state_next;
  oupe_pkg::op_t         step, step_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= oupe_pkg::CS_IDLE;
      step  <= oupe_pkg::OP_CHK;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  always_comb begin
    state_next = state;
    step_next  = step;
    unique case (state)
      oupe_pkg::CS_IDLE: begin
        if (in_valid && in_last) begin
          state_next = oupe_pkg::CS_ISSUE;
          step_next  = oupe_pkg::OP_CHK;
        end
      end
      oupe_pkg::CS_ISSUE: state_next = sts.stop ? oupe_pkg::CS_DONE : oupe_pkg::CS_WAIT;
      oupe_pkg::CS_WAIT: begin
        if (sts.done) begin
          if (step == oupe_pkg::OP_V) begin
            state_next = oupe_pkg::CS_DONE;
          end else begin
            step_next  = oupe_pkg::op_t'(5'(step + 5'd1));
            state_next = oupe_pkg::CS_ISSUE;
          end
        end
      end
      oupe_pkg::CS_DONE: if (sts.out_free) state_next = oupe_pkg::CS_IDLE;
      default: state_next = oupe_pkg::CS_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = (state == oupe_pkg::CS_IDLE);
    cmd.accum  = (state == oupe_pkg::CS_IDLE) && in_valid;
    cmd.issue  = (state == oupe_pkg::CS_ISSUE) && !sts.stop;
    cmd.finish = (state == oupe_pkg::CS_WAIT) && sts.done;
    cmd.load   = (state == oupe_pkg::CS_DONE) && sts.out_free;
    cmd.op     = step;
  end

endmodule

>>> rtl/ou_parameter_estimator.sv
// Samples stream in at one beat per cycle while idle; each beat is folded into the sums the
// same cycle. After the beat flagged last, the estimate is paced by the bit-serial 64x64
// multiplier (16 products), the 128-bit restoring divider (3 quotients) and the two iterative
// log2 runs. No sample is taken while the estimate runs; the next series may stream in while
// a result waits on the output. Reset (rst, synchronous, active high) clears all sums, the
// count and the output valid.
module ou_parameter_estimator (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,  // [15:0] sample
  input  logic        s_tlast,  // last
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,  // [15:0] mean_est, [39:16] rate_est, [71:40] variance_est
  output logic [2:0]  m_tuser   // [2:0] status
);

  oupe_pkg::dp_cmd_t cmd;
  oupe_pkg::dp_sts_t sts;

  // sequencer: accept beats, then step through the estimation
  oupe_ctrl u_ctrl (
    .clk,
    .rst,
    .in_valid (s_tvalid),
    .in_last  (s_tlast),
    .in_ready (s_tready),
    .cmd,
    .sts
  );

  // sums, arithmetic units and the output register
  oupe_datapath u_dp (
    .clk,
    .rst,
    .cmd,
    .sts,
    .in_sample (s_tdata),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata),
    .out_stat  (m_tuser)
  );

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int IDLE_LIMIT = 20000;

  typedef struct {
    logic [15:0] mean;
    logic [23:0] rate;
    logic [31:0] variance;
    oupe_pkg::status_t st;
  } estimate_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [71:0] m_tdata;   // [15:0] mean_est, [39:16] rate_est, [71:40] variance_est
  logic [2:0]  m_tuser;   // [2:0] status

  ou_parameter_estimator u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state: previous sample, count and the five transition sums
  longint   pr_prev, pr_count;
  longint   pr_sx, pr_sy, pr_sxx, pr_syy, pr_sxy;
  estimate_t est_q[$];
  int       errors = 0;
  int       beats_in = 0, results_seen = 0, series_sent = 0;
  int       status_hits[5];
  bit       tx_quiet = 0, rx_quiet = 0;

  function automatic longint unsigned log2_fix(longint unsigned v);
    int unsigned k;
    longint unsigned t, mnt, frac;
    k = 0; t = v; frac = 0;
    while (t > 1) begin
      t = t >> 1;
      k++;
    end
    mnt = (k >= 31) ? (v >> (k - 31)) : (v << (31 - k));
    for (int i = 1; i <= 24; i++) begin
      mnt = (mnt * mnt) >> 31;
      if (mnt >= 64'h1_0000_0000) begin
        mnt = mnt >> 1;
        frac |= 64'd1 << (24 - i);
      end
    end
    return (longint'(k) << 24) | frac;
  endfunction

  function automatic estimate_t estimate_ou();
    estimate_t r;
    longint n, mu, a, b, c, la, lb, rate;
    logic signed [127:0] num, den, t1, t2, dd, pp;
    logic [127:0] an, ad, q, nn, d_abs, ff, vv;
    longint unsigned mag56, amag, l40, g, s2;
    bit neg;
    r.mean = '0; r.rate = '0; r.variance = '0; r.st = oupe_pkg::STAT_OK;
    n = pr_count - 1;
    if (pr_count > oupe_pkg::MAX_SAMPLES) begin r.st = oupe_pkg::STAT_TOO_MANY; return r; end
    if (pr_count < 3) begin r.st = oupe_pkg::STAT_TOO_FEW; return r; end
    t1 = pr_sy; t2 = pr_sxx; num = t1 * t2;
    t1 = pr_sx; t2 = pr_sxy; num = num - t1 * t2;
    t1 = n; t2 = pr_sxx - pr_sxy; den = t1 * t2;
    t1 = pr_sx; t2 = pr_sx - pr_sy; den = den - t1 * t2;
    if (den == 0) begin r.st = oupe_pkg::STAT_ZERO_DEN; return r; end
    an = num < 0 ? -num : num;
    ad = den < 0 ? -den : den;
    neg = (num < 0) != (den < 0);
    q = ((an << 1) + ad) / (ad << 1);
    if (neg) mu = (q > 128'd32768) ? -32768 : -longint'(q[63:0]);
    else mu = (q > 128'd32767) ? 32767 : longint'(q[63:0]);
    r.mean = mu[15:0];
    a = pr_sxx - 2 * mu * pr_sx + n * mu * mu;
    b = pr_sxy - mu * pr_sx - mu * pr_sy + n * mu * mu;
    c = pr_syy - 2 * mu * pr_sy + n * mu * mu;
    if (a <= 0 || b <= 0) begin r.st = oupe_pkg::STAT_BAD_LOG; return r; end
    la = log2_fix(a);
    lb = log2_fix(b);
    neg = la < lb;
    mag56 = (neg ? lb - la : la - lb) * longint'(oupe_pkg::LN2_Q32);
    amag = (mag56 + (64'd1 << 39)) >> 40;
    l40 = mag56 >> 16;
    if (neg) rate = (amag > 64'd8388608) ? -8388608 : -longint'(amag);
    else rate = (amag > 64'd8388607) ? 8388607 : longint'(amag);
    r.rate = rate[23:0];
    t1 = a; nn = t1 * t1;
    t1 = a - b; t2 = a + b; dd = t1 * t2;
    d_abs = dd < 0 ? -dd : dd;
    // shift both terms of the beta factor together until A^2 fits 94 bits
    while (nn[127:94] != 0) begin
      nn = nn >> 1;
      d_abs = d_abs >> 1;
    end
    if (d_abs == 0) begin r.st = oupe_pkg::STAT_ZERO_DEN; return r; end
    q = (nn << 32) / d_abs;
    g = (q[127:64] != 0) ? '1 : q[63:0];
    if (c < 0) c = 0;
    t1 = c; t2 = a; pp = t1 * t2;
    t1 = b; pp = pp - t1 * t1;
    if (pp < 0) pp = 0;
    t1 = a; t2 = n;
    q = (128'(pp) << 16) / 128'(t1 * t2);
    s2 = (q[127:64] != 0) ? '1 : q[63:0];
    ff = (128'(2 * l40) * 128'(g)) >> 24;
    if (ff[127:64] != 0) r.variance = (s2 != 0) ? 32'hFFFF_FFFF : 32'd0;
    else begin
      vv = 128'(ff[63:0]) * 128'(s2);
      r.variance = (vv[127:64] > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : vv[95:64];
    end
    return r;
  endfunction

  function automatic void clear_sums();
    pr_prev = 0; pr_count = 0;
    pr_sx = 0; pr_sy = 0; pr_sxx = 0; pr_syy = 0; pr_sxy = 0;
  endfunction

  // fold one accepted beat into the predictor; a last beat yields one estimate
  function automatic void fold_sample(logic [15:0] raw, logic lst);
    longint x;
    x = longint'($signed(raw));
    if (pr_count == 0) begin
      pr_prev = x;
      pr_count = 1;
    end else if (pr_count < oupe_pkg::MAX_SAMPLES) begin
      pr_sx += pr_prev;
      pr_sy += x;
      pr_sxx += pr_prev * pr_prev;
      pr_syy += x * x;
      pr_sxy += pr_prev * x;
      pr_prev = x;
      pr_count++;
    end else begin
      pr_count = oupe_pkg::MAX_SAMPLES + 1;
    end
    if (lst) begin
      est_q.push_back(estimate_ou());
      clear_sums();
    end
  endfunction

  // drive one beat after a random gap, hold until accepted
  task automatic send_sample(logic [15:0] x, logic lst);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= x;
    s_tlast  <= lst;
    do @(posedge clk); while (!s_tready);
    beats_in++;
    fold_sample(x, lst);
  endtask

  // receiver: random stall before each result, then ready until a beat moves
  initial begin
    int stall;
    forever begin
      stall = rx_quiet ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      if ($urandom_range(0, 7) == 0) rx_quiet = ~rx_quiet;
    end
  end

  // check every result beat against the oldest estimate
  always @(posedge clk) begin
    estimate_t e;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (est_q.size() == 0) begin
        $display("%0t: unexpected result, actual data %h status %0d", $time, m_tdata, m_tuser);
        errors++;
      end else begin
        e = est_q.pop_front();
        if (e.st <= oupe_pkg::STAT_BAD_LOG) status_hits[e.st]++;
        if (m_tdata[15:0] !== e.mean) begin
          $display("%0t: mean_est expected %h actual %h", $time, e.mean, m_tdata[15:0]);
          errors++;
        end
        if (m_tdata[39:16] !== e.rate) begin
          $display("%0t: rate_est expected %h actual %h", $time, e.rate, m_tdata[39:16]);
          errors++;
        end
        if (m_tdata[71:40] !== e.variance) begin
          $display("%0t: variance_est expected %h actual %h", $time, e.variance,
                   m_tdata[71:40]);
          errors++;
        end
        if (m_tuser !== e.st) begin
          $display("%0t: status expected %0d actual %0d", $time, e.st, m_tuser);
          errors++;
        end
      end
    end
  end

  // watchdog: count cycles in which no beat moves on either side
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic logic [15:0] clamp16(int v);
    if (v > 32767) return 16'h7FFF;
    if (v < -32768) return 16'h8000;
    return 16'(v);
  endfunction

  // one series of len samples; style 0 reverting walk, 1 full range noise, 2 wide walk
  task automatic send_series(int len, int style);
    int x, mu, amp, pull;
    logic [15:0] s;
    mu = int'($urandom_range(0, 65535)) - 32768;
    amp = (style == 2) ? int'($urandom_range(256, 8000)) : int'($urandom_range(1, 600));
    pull = int'($urandom_range(1, 15));
    x = mu + int'($urandom_range(0, 2 * amp)) - amp;
    series_sent++;
    for (int i = 0; i < len; i++) begin
      if (style == 1) s = 16'($urandom);
      else begin
        x = x + ((mu - x) * pull) / 16 + int'($urandom_range(0, 2 * amp)) - amp;
        s = clamp16(x);
        x = $signed(s);
      end
      send_sample(s, i == len - 1);
    end
  endtask

  task automatic test_directed();
    // too few: one and two samples
    send_sample(16'h7FFF, 1'b1);
    send_sample(16'h8000, 1'b0);
    send_sample(16'h7FFF, 1'b1);
    // constant series: mean denominator vanishes
    repeat (3) send_sample(16'h0100, 1'b0);
    send_sample(16'h0100, 1'b1);
    // alternating extremes: negative cross term, bad log argument
    send_sample(16'h8000, 1'b0);
    send_sample(16'h7FFF, 1'b0);
    send_sample(16'h8000, 1'b0);
    send_sample(16'h7FFF, 1'b0);
    send_sample(16'h8000, 1'b1);
    // shortest valid series, then a short walk
    send_sample(16'h0000, 1'b0);
    send_sample(16'h0010, 1'b0);
    send_sample(16'hFFF0, 1'b1);
    send_series(8, 0);
  endtask

  task automatic test_too_many();
    for (int i = 0; i < oupe_pkg::MAX_SAMPLES + 3; i++)
      send_sample(16'($urandom), i == oupe_pkg::MAX_SAMPLES + 2);
  endtask

  task automatic test_random();
    int len, style;
    while (beats_in < 1450 + oupe_pkg::MAX_SAMPLES) begin
      tx_quiet = ($urandom_range(0, 3) == 0);
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 4) : $urandom_range(3, 40);
      style = $urandom_range(0, 5);
      send_series(len, style == 5 ? 1 : (style >= 3 ? 2 : 0));
    end
    tx_quiet = 0;
  endtask

  initial begin
    clear_sums();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_too_many();
    test_random();
    s_tvalid <= 1'b0;
    s_tlast  <= 1'b0;
    while (est_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("Covered %0d beats in %0d series, %0d results checked, %0d errors.",
             beats_in, series_sent, results_seen, errors);
    $display("Statuses ok/few/many/zero_den/bad_log: %0d/%0d/%0d/%0d/%0d", status_hits[0],
             status_hits[1], status_hits[2], status_hits[3], status_hits[4]);
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

>>> sim.f
rtl/oupe_pkg.sv
rtl/oupe_mul.sv
rtl/oupe_div.sv
rtl/oupe_log2.sv
rtl/oupe_datapath.sv
rtl/oupe_ctrl.sv
rtl/ou_parameter_estimator.sv
sim/tb.sv
